// File: design/smm_pkg.sv
// Shared types and constants for the matrix multiply block.
`timescale 1ns / 1ps

package smm_pkg;

    localparam int ROW_W  = 3;
    localparam int VAL_W  = 32;
    localparam int SIZE_W = 2;

    localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 2'd3;

    // action codes
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    // matrix_sel codes
    localparam logic SEL_A = 1'b0;
    localparam logic SEL_B = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } smm_state_t;

endpackage

// File: design/smm_in_if.sv
// Request channel interface: load and compute requests.
`timescale 1ns / 1ps

interface smm_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic                        matrix_sel;
    logic [smm_pkg::ROW_W-1:0]   load_row;
    logic [smm_pkg::ROW_W-1:0]   load_col;
    logic signed [smm_pkg::VAL_W-1:0] element_value;

    modport source (output valid, action, matrix_sel, load_row, load_col, element_value,
                    input ready);
    modport sink   (input valid, action, matrix_sel, load_row, load_col, element_value,
                    output ready);
endinterface

// File: design/smm_out_if.sv
// Result channel interface: product elements in row-major order.
`timescale 1ns / 1ps

interface smm_out_if;
    logic                        valid;
    logic                        ready;
    logic [smm_pkg::ROW_W-1:0]   out_row;
    logic [smm_pkg::ROW_W-1:0]   out_col;
    logic signed [smm_pkg::VAL_W-1:0] product_value;
    logic                        last;

    modport source (output valid, out_row, out_col, product_value, last,
                    input ready);
    modport sink   (input valid, out_row, out_col, product_value, last,
                    output ready);
endinterface

// File: design/strassen_matrix_multiply.sv
// Top level: square matrix multiply over 32-bit wrapping integers.
// Requests: a load request writes one element; a compute request streams out n*n
//   product elements (n = side in use), and waits while the output stalls.
// Throughput: one request at a time; each product element takes n reads of the
//   A and B memory read ports, then a multiply/accumulate drain and emit.
// Reset: rst_n async, active low; clears control and sets size_log2 to 3.
//   The A and B memories are not cleared and hold garbage until written.
`timescale 1ns / 1ps

module strassen_matrix_multiply #(
    parameter int MAX_SIDE = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [smm_pkg::SIZE_W-1:0]   cfg_data,
    smm_in_if.sink                       in_ch,
    smm_out_if.source                    out_ch
);
    import smm_pkg::*;

    // Storage geometry. Entries are row*MAX_SIDE+col, so MAX_SIDE need not
    // be a power of two.
    localparam int CELLS    = MAX_SIDE * MAX_SIDE;
    localparam int IDX_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SIDE_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    // floor(log2(MAX_SIDE)): largest power-of-two side that fits
    localparam int MAX_LOG2 = $clog2(MAX_SIDE + 1) - 1;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] size_log2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= SIZE_LOG2_RESET;
        end
        else if (cfg_we)
        begin
            size_log2_reg <= cfg_data;
        end
    end

    // side in use minus one; a side above MAX_SIDE is clamped to the largest
    // power of two that fits
    logic [SIZE_W-1:0] n_log2;
    logic [SIDE_W-1:0] n1_cur;

    always_comb
    begin
        if (int'(size_log2_reg) > MAX_LOG2)
        begin
            n_log2 = SIZE_W'(MAX_LOG2);
        end
        else
        begin
            n_log2 = size_log2_reg;
        end
        n1_cur = SIDE_W'((1 << n_log2) - 1);
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    smm_state_t        state_reg,  state_next;
    logic [SIDE_W-1:0] n1_reg,     n1_next;
    logic [SIDE_W-1:0] i_reg,      i_next;
    logic [SIDE_W-1:0] j_reg,      j_next;
    logic [SIDE_W-1:0] k_reg,      k_next;

    // multiply/accumulate pipeline tags
    logic rd_v_reg,  rd_first_reg,  rd_last_reg;
    logic mul_v_reg, mul_first_reg, mul_last_reg;
    logic issue;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]        out_row_reg;
    logic [ROW_W-1:0]        out_col_reg;
    logic signed [VAL_W-1:0] out_val_reg;
    logic                    out_last_reg;
    logic                    out_load;

    logic in_fire;
    logic load_we;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;

    // loads outside the store are dropped
    assign load_we = in_fire && (in_ch.action == ACT_LOAD)
                     && (int'(in_ch.load_row) < MAX_SIDE)
                     && (int'(in_ch.load_col) < MAX_SIDE);

    // ------------------------------------------------------------------
    // Sequencer: per product element, issue n read pairs (k loop), wait
    // for the MAC pipe to drain, then hand the sum to the output register.
    // Loads are only taken in IDLE, so a memory write never overlaps the
    // reads of a compute and no forwarding is needed.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        n1_next    = n1_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        issue      = 1'b0;
        out_load   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_ch.action == ACT_COMPUTE))
                begin
                    n1_next    = n1_cur;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                issue = 1'b1;
                if (k_reg == n1_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // final product of this element lands in the accumulator now
                if (mul_v_reg && mul_last_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load = 1'b1;
                    k_next   = '0;
                    if ((i_reg == n1_reg) && (j_reg == n1_reg))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        if (j_reg == n1_reg)
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n1_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n1_reg    <= n1_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // ------------------------------------------------------------------
    // A and B memories: one write port (loads), one registered read port
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] a_mem [CELLS];
    logic [VAL_W-1:0] b_mem [CELLS];
    logic [VAL_W-1:0] a_q, b_q;
    logic [IDX_W-1:0] w_addr, a_raddr, b_raddr;

    assign w_addr  = IDX_W'(int'(in_ch.load_row) * MAX_SIDE + int'(in_ch.load_col));
    assign a_raddr = IDX_W'(int'(i_reg) * MAX_SIDE + int'(k_reg));
    assign b_raddr = IDX_W'(int'(k_reg) * MAX_SIDE + int'(j_reg));

    always_ff @(posedge clk)
    begin
        if (load_we && (in_ch.matrix_sel == SEL_A))
        begin
            a_mem[w_addr] <= in_ch.element_value;
        end
        if (load_we && (in_ch.matrix_sel == SEL_B))
        begin
            b_mem[w_addr] <= in_ch.element_value;
        end
        a_q <= a_mem[a_raddr];
        b_q <= b_mem[b_raddr];
    end

    // ------------------------------------------------------------------
    // MAC pipe: read data -> product register -> accumulator.
    // Low 32 bits of the product are the same signed or unsigned.
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] prod_reg;
    logic [VAL_W-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg      <= 1'b0;
            rd_first_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            mul_v_reg     <= 1'b0;
            mul_first_reg <= 1'b0;
            mul_last_reg  <= 1'b0;
        end
        else
        begin
            rd_v_reg      <= issue;
            rd_first_reg  <= issue && (k_reg == '0);
            rd_last_reg   <= issue && (k_reg == n1_reg);
            mul_v_reg     <= rd_v_reg;
            mul_first_reg <= rd_first_reg;
            mul_last_reg  <= rd_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_q * b_q;
        if (mul_v_reg)
        begin
            acc_reg <= (mul_first_reg ? '0 : acc_reg) + prod_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: parts the result side from the sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg  <= ROW_W'(i_reg);
            out_col_reg  <= ROW_W'(j_reg);
            out_val_reg  <= acc_reg;
            out_last_reg <= (i_reg == n1_reg) && (j_reg == n1_reg);
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_row       = out_row_reg;
    assign out_ch.out_col       = out_col_reg;
    assign out_ch.product_value = out_val_reg;
    assign out_ch.last          = out_last_reg;

endmodule

// File: design/smm_checker.sv
// Port-level assertions for the matrix multiply block, with bind.
`timescale 1ns / 1ps

module smm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       in_action,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [smm_pkg::ROW_W-1:0]  out_row,
    input logic [smm_pkg::ROW_W-1:0]  out_col,
    input logic                       out_last
);
    import smm_pkg::*;

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
                                    && $stable(out_last))
        else $error("result changed while stalled");

    // compute request locks out further requests
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_action == ACT_COMPUTE) |=> !in_ready)
        else $error("request taken during compute");

    // a load leaves the request channel ready again in the next cycle
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_action == ACT_LOAD) |=> in_ready)
        else $error("load did not complete in one cycle");

    // the final element sits on the diagonal corner
    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> (out_row == out_col))
        else $error("last flag off the diagonal");

endmodule

bind strassen_matrix_multiply smm_checker u_smm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_action (in_ch.action),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_row   (out_ch.out_row),
    .out_col   (out_ch.out_col),
    .out_last  (out_ch.last)
);
